// ----- hdl/rc4sc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared types and constants for the RC4 stream cipher block: permutation
// geometry, command codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

    localparam int BYTE_W      = 8;
    localparam int SBOX_DEPTH  = 256;
    localparam int SBOX_AW     = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [SBOX_AW-1:0] SBOX_LAST = 8'hFF;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_D_RDX = 9'b0_0000_0010,
        ST_D_RDY = 9'b0_0000_0100,
        ST_D_WRI = 9'b0_0000_1000,
        ST_K_INIT = 9'b0_0001_0000,
        ST_K_RDS = 9'b0_0010_0000,
        ST_K_RDJ = 9'b0_0100_0000,
        ST_K_WRN = 9'b0_1000_0000,
        ST_K_WRJ = 9'b1_0000_0000
    } state_t;

endpackage
`default_nettype wire

// ----- hdl/rc4_stream_cipher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 keystream generator and XOR stage with a key store and schedule.
// ----------------------------------------------------------------------------
// One input word is taken at a time. A data word (tuser = 1) has its result
// loaded in the output register after three dependent reads of the
// permutation RAM (one read and one write port), with the swap written back
// alongside the last read and in the final state. The input is ready again
// in the cycle after that, so a new data word is not taken before the last is
// through, and later while the previous result still waits for m_axis_tready.
// A key word is stored while the block stays in ST_IDLE; a key word with
// tlast set also runs the key schedule, ST_K_INIT and then 256 steps, each
// being two reads and two writes of the RAM in turn. The permutation is the
// identity after reset and data words sent before a key are still encrypted
// with it. The result register decouples the output: a new word is accepted
// while an earlier result still waits for m_axis_tready. Key bytes beyond
// KEY_MAX are dropped; encryption and decryption are the same.
// ----------------------------------------------------------------------------
module rc4_stream_cipher
    import rc4sc_pkg::*;
#(
    parameter int KEY_MAX = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] key_byte, [15:8] data_byte
    input  wire logic                 s_axis_tuser,   // [0] command
    input  wire logic                 s_axis_tlast,
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output      logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output      logic                 m_axis_tlast
);

    localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KEY_CW = $clog2(KEY_MAX + 1);
    localparam logic [KEY_CW-1:0] KEY_CAP = KEY_CW'(KEY_MAX);

    state_t state_reg, state_next;

    logic [SBOX_AW-1:0] i_reg, i_next;
    logic [SBOX_AW-1:0] j_reg, j_next;
    logic [BYTE_W-1:0]  sx_reg, sx_next;
    logic [BYTE_W-1:0]  sy_reg, sy_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic               last_reg, last_next;
    logic [KEY_CW-1:0]  kcount_reg, kcount_next;
    logic [KEY_CW-1:0]  klen_reg, klen_next;
    logic [KEY_AW-1:0]  pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    // permutation RAM, valid bits give the identity for unwritten entries
    logic [BYTE_W-1:0]     sbox_mem [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] sb_valid_reg;
    logic [BYTE_W-1:0]     sbox_q_reg;
    logic                  sb_rvalid_reg;
    logic [SBOX_AW-1:0]    sb_raddr_reg;
    logic                  sb_re, sb_we, sb_clr;
    logic [SBOX_AW-1:0]    sb_raddr, sb_waddr;
    logic [BYTE_W-1:0]     sb_wdata;
    logic [BYTE_W-1:0]     sbox_rd;

    // key store
    logic [BYTE_W-1:0] key_mem [KEY_MAX];
    logic [BYTE_W-1:0] key_q_reg;
    logic              km_we, km_re;

    logic [BYTE_W-1:0] ks;
    logic [BYTE_W-1:0] kb;
    logic [KEY_CW-1:0] pos_inc;
    logic              key_room;

    assign sbox_rd  = sb_rvalid_reg ? sbox_q_reg : sb_raddr_reg;
    assign key_room = (kcount_reg < KEY_CAP);
    assign kb       = (klen_reg == '0) ? '0 : key_q_reg;
    assign pos_inc  = KEY_CW'(pos_reg) + KEY_CW'(1);

    // RAM read was issued alongside the write of j; i is written now
    always_comb
    begin
        if (sb_raddr_reg == i_reg)
            ks = sy_reg;
        else if (sb_raddr_reg == j_reg)
            ks = sx_reg;
        else
            ks = sbox_rd;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        kcount_next   = kcount_reg;
        klen_next     = klen_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        sb_re         = 1'b0;
        sb_raddr      = i_reg;
        sb_we         = 1'b0;
        sb_waddr      = i_reg;
        sb_wdata      = sx_reg;
        sb_clr        = 1'b0;
        km_we         = 1'b0;
        km_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    data_next = s_axis_tdata[15:8];
                    last_next = s_axis_tlast;
                    if (s_axis_tuser == CMD_DATA)
                    begin
                        i_next     = i_reg + SBOX_AW'(1);
                        sb_re      = 1'b1;
                        sb_raddr   = i_reg + SBOX_AW'(1);
                        state_next = ST_D_RDX;
                    end
                    else
                    begin
                        if (key_room)
                        begin
                            km_we       = 1'b1;
                            kcount_next = kcount_reg + KEY_CW'(1);
                        end
                        if (s_axis_tlast)
                        begin
                            klen_next   = key_room ? kcount_reg + KEY_CW'(1) : kcount_reg;
                            kcount_next = '0;
                            state_next  = ST_K_INIT;
                        end
                    end
                end
            end
            ST_D_RDX:
            begin
                sx_next    = sbox_rd;
                j_next     = j_reg + sbox_rd;
                sb_re      = 1'b1;
                sb_raddr   = j_reg + sbox_rd;
                state_next = ST_D_RDY;
            end
            ST_D_RDY:
            begin
                sy_next    = sbox_rd;
                sb_we      = 1'b1;
                sb_waddr   = j_reg;
                sb_wdata   = sx_reg;
                sb_re      = 1'b1;
                sb_raddr   = sx_reg + sbox_rd;
                state_next = ST_D_WRI;
            end
            ST_D_WRI:
            begin
                sb_we    = 1'b1;
                sb_waddr = i_reg;
                sb_wdata = sy_reg;
                // hold here while the previous word is still unclaimed
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_byte_next = data_reg ^ ks;
                    out_last_next = last_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_K_INIT:
            begin
                sb_clr     = 1'b1;
                i_next     = '0;
                j_next     = '0;
                pos_next   = '0;
                state_next = ST_K_RDS;
            end
            ST_K_RDS:
            begin
                sb_re      = 1'b1;
                sb_raddr   = i_reg;
                km_re      = 1'b1;
                state_next = ST_K_RDJ;
            end
            ST_K_RDJ:
            begin
                sx_next    = sbox_rd;
                j_next     = j_reg + sbox_rd + kb;
                sb_re      = 1'b1;
                sb_raddr   = j_reg + sbox_rd + kb;
                state_next = ST_K_WRN;
            end
            ST_K_WRN:
            begin
                sb_we      = 1'b1;
                sb_waddr   = i_reg;
                sb_wdata   = sbox_rd;
                state_next = ST_K_WRJ;
            end
            ST_K_WRJ:
            begin
                sb_we    = 1'b1;
                sb_waddr = j_reg;
                sb_wdata = sx_reg;
                // i wraps back to zero after the last step
                i_next   = i_reg + SBOX_AW'(1);
                pos_next = (pos_inc >= klen_reg) ? '0 : pos_inc[KEY_AW-1:0];
                if (i_reg == SBOX_LAST)
                begin
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_K_RDS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            kcount_reg   <= '0;
            m_valid_reg  <= 1'b0;
            sb_valid_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            kcount_reg  <= kcount_next;
            m_valid_reg <= m_valid_next;
            if (sb_clr)
                sb_valid_reg <= '0;
            else if (sb_we)
                sb_valid_reg[sb_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        klen_reg     <= klen_next;
        pos_reg      <= pos_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // read-first RAM; the valid bit is sampled with the data
    always_ff @(posedge clk)
    begin
        if (sb_we)
            sbox_mem[sb_waddr] <= sb_wdata;
        if (sb_re)
        begin
            sbox_q_reg    <= sbox_mem[sb_raddr];
            sb_rvalid_reg <= sb_valid_reg[sb_raddr];
            sb_raddr_reg  <= sb_raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (km_we)
            key_mem[kcount_reg[KEY_AW-1:0]] <= s_axis_tdata[7:0];
        if (km_re)
            key_q_reg <= key_mem[pos_reg];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- hdl/rc4sc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rc4sc_checker
// Port-level checks for the RC4 stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rc4sc_checker
    import rc4sc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 s_axis_tuser,   // [0] command
    input wire logic                 s_axis_tlast,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte
    input wire logic                 m_axis_tlast
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // a data word occupies the RAM, and keeps the input busy, through ST_D_RDX, ST_D_RDY and ST_D_WRI
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser == CMD_DATA |=>
            !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken during data word processing");

    // the final key word starts the schedule
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser == CMD_KEY && s_axis_tlast |=>
            !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken during key schedule");

    // a key word that is not final leaves the block ready
    a_key_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser == CMD_KEY && !s_axis_tlast |=> s_axis_tready)
        else $error("block stalled after a plain key word");

endmodule

bind rc4_stream_cipher rc4sc_checker u_rc4sc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
